>>> sv/pbmt_pkg.sv
// Shared types, constants and a helper function for the pair bucket maximum tracker.
`timescale 1ns / 1ps

package pbmt_pkg;

    localparam int NUM_CHROM  = 32;
    localparam int CHROM_W    = 5;
    localparam int PAIR_COUNT = NUM_CHROM * (NUM_CHROM + 1) / 2;
    localparam int PAIR_IDX_W = $clog2(PAIR_COUNT);
    localparam int LOD_W      = 24;
    localparam int POS_W      = 16;
    localparam int SQTL_W     = 23;
    localparam int MASK_W     = 32;
    localparam int CMD_DEPTH  = 2;
    localparam int CMD_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int RES_DEPTH  = 2;
    localparam int RES_PTR_W  = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;

    typedef enum logic [1:0] {
        REQ_SCORE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        CRIT_JOINT = 2'd0,
        CRIT_ADD   = 2'd1,
        CRIT_INTER = 2'd2
    } crit_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } back_state_t;

    typedef struct packed {
        req_t                    kind;
        logic [PAIR_IDX_W-1:0]   pair_idx;
        logic [CHROM_W-1:0]      chrom_a;
        logic [CHROM_W-1:0]      chrom_b;
        logic [POS_W-1:0]        pos_a;
        logic [POS_W-1:0]        pos_b;
        logic signed [LOD_W-1:0] lod_full;
        logic signed [LOD_W-1:0] lod_add;
        logic signed [LOD_W-1:0] lod_x_single;
        logic signed [LOD_W:0]   lod_diff;
        logic                    on_diagonal;
        crit_t                   criterion;
    } cmd_t;

    typedef struct packed {
        logic signed [LOD_W-1:0] lod_full;
        logic signed [LOD_W-1:0] lod_add;
        logic [POS_W-1:0]        pos_first;
        logic [POS_W-1:0]        pos_second;
    } rec_t;

    typedef struct packed {
        rec_t joint;
        rec_t additive;
        rec_t inter;
    } entry_t;

    typedef struct packed {
        logic signed [LOD_W-1:0] best;
        logic signed [LOD_W-1:0] best_x;
    } single_t;

    typedef struct packed {
        logic signed [LOD_W-1:0] lod_full_at_max;
        logic signed [LOD_W-1:0] lod_add_at_max;
        logic [POS_W-1:0]        pos_first;
        logic [POS_W-1:0]        pos_second;
        logic [SQTL_W-1:0]       lod_single_qtl;
    } res_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } back_status_t;

    function automatic logic [PAIR_IDX_W-1:0] pair_index(
        input logic [CHROM_W-1:0] a,
        input logic [CHROM_W-1:0] b
    );
        logic [CHROM_W-1:0]   lo;
        logic [CHROM_W-1:0]   hi;
        logic [2*CHROM_W-1:0] tri_v;
        logic [PAIR_IDX_W:0]  idx_w;
        lo    = (a < b) ? a : b;
        hi    = (a < b) ? b : a;
        tri_v = (2*CHROM_W)'(lo) * (2*CHROM_W)'(lo - CHROM_W'(1));
        idx_w = (PAIR_IDX_W+1)'(lo) * (PAIR_IDX_W+1)'(NUM_CHROM)
              - (PAIR_IDX_W+1)'(tri_v >> 1)
              + (PAIR_IDX_W+1)'(hi - lo);
        return idx_w[PAIR_IDX_W-1:0];
    endfunction

endpackage

>>> sv/pbmt_front.sv
// Front end: accepts request items, classifies them and builds queue commands.
`timescale 1ns / 1ps

module pbmt_front (
    input  logic                                     push,
    input  logic                                     full,
    input  logic [1:0]                               req_type,
    input  logic [pbmt_pkg::CHROM_W-1:0]             chrom_a,
    input  logic [pbmt_pkg::CHROM_W-1:0]             chrom_b,
    input  logic [pbmt_pkg::POS_W-1:0]               pos_a,
    input  logic [pbmt_pkg::POS_W-1:0]               pos_b,
    input  logic signed [pbmt_pkg::LOD_W-1:0]        lod_full,
    input  logic signed [pbmt_pkg::LOD_W-1:0]        lod_add,
    input  logic signed [pbmt_pkg::LOD_W-1:0]        lod_x_single,
    input  logic                                     on_diagonal,
    input  logic [1:0]                               criterion,
    output logic                                     cmd_push,
    output pbmt_pkg::cmd_t                           cmd
);

    logic accept;
    logic known_req;

    assign accept = push && !full;

    always_comb
    begin
        case (pbmt_pkg::req_t'(req_type))
            pbmt_pkg::REQ_SCORE,
            pbmt_pkg::REQ_READ,
            pbmt_pkg::REQ_CLEAR: known_req = 1'b1;
            default:             known_req = 1'b0;
        endcase
    end

    assign cmd_push = accept && known_req;

    always_comb
    begin
        cmd.kind         = pbmt_pkg::req_t'(req_type);
        cmd.pair_idx     = pbmt_pkg::pair_index(chrom_a, chrom_b);
        cmd.chrom_a      = chrom_a;
        cmd.chrom_b      = chrom_b;
        cmd.pos_a        = pos_a;
        cmd.pos_b        = pos_b;
        cmd.lod_full     = lod_full;
        cmd.lod_add      = lod_add;
        cmd.lod_x_single = lod_x_single;
        cmd.lod_diff     = $signed({lod_full[pbmt_pkg::LOD_W-1], lod_full})
                         - $signed({lod_add[pbmt_pkg::LOD_W-1], lod_add});
        cmd.on_diagonal  = on_diagonal;
        cmd.criterion    = pbmt_pkg::crit_t'(criterion);
    end

endmodule

>>> sv/pbmt_cmd_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module pbmt_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  pbmt_pkg::cmd_t wr_data,
    input  logic           rd_en,
    output pbmt_pkg::cmd_t rd_data,
    output logic           q_full,
    output logic           q_empty
);

    pbmt_pkg::cmd_t slot_reg [pbmt_pkg::CMD_DEPTH];

    logic [pbmt_pkg::CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pbmt_pkg::CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pbmt_pkg::CMD_PTR_W:0]   count_reg, count_next;
    logic                           do_wr;
    logic                           do_rd;

    assign q_full  = (count_reg == (pbmt_pkg::CMD_PTR_W+1)'(pbmt_pkg::CMD_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == pbmt_pkg::CMD_PTR_W'(pbmt_pkg::CMD_DEPTH - 1))
                        ? '0 : wr_ptr_reg + pbmt_pkg::CMD_PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == pbmt_pkg::CMD_PTR_W'(pbmt_pkg::CMD_DEPTH - 1))
                        ? '0 : rd_ptr_reg + pbmt_pkg::CMD_PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (pbmt_pkg::CMD_PTR_W+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (pbmt_pkg::CMD_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/pbmt_back.sv
// Back end: pair and single stores, read-modify-write updates, reads and clearing sweep.
`timescale 1ns / 1ps

module pbmt_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pbmt_pkg::cmd_t                cmd_head,
    input  logic                          cmd_empty,
    output logic                          cmd_pop,
    input  logic [pbmt_pkg::MASK_W-1:0]   x_mask,
    output pbmt_pkg::res_t                res_data,
    output logic                          res_push,
    input  logic                          res_full,
    output pbmt_pkg::back_status_t        status
);

    pbmt_pkg::entry_t  pair_mem [pbmt_pkg::PAIR_COUNT];
    pbmt_pkg::single_t sgl_mem  [pbmt_pkg::NUM_CHROM];

    pbmt_pkg::back_state_t                state_reg, state_next;
    logic [pbmt_pkg::PAIR_IDX_W-1:0]      sweep_reg, sweep_next;
    pbmt_pkg::cmd_t                       cmd_reg;
    pbmt_pkg::entry_t                     pair_rd_reg;
    pbmt_pkg::single_t                    sgl_a_reg;
    pbmt_pkg::single_t                    sgl_b_reg;

    logic                                 pair_we;
    logic [pbmt_pkg::PAIR_IDX_W-1:0]      pair_waddr;
    pbmt_pkg::entry_t                     pair_wdata;
    logic                                 sgl_we;
    logic [pbmt_pkg::CHROM_W-1:0]         sgl_waddr;
    pbmt_pkg::single_t                    sgl_wdata;

    pbmt_pkg::rec_t                       new_rec;
    pbmt_pkg::entry_t                     upd_entry;
    pbmt_pkg::single_t                    upd_single;
    logic signed [pbmt_pkg::LOD_W:0]      stored_diff;
    pbmt_pkg::rec_t                       sel_rec;
    logic                                 use_x;
    logic signed [pbmt_pkg::LOD_W-1:0]    s1;
    logic signed [pbmt_pkg::LOD_W-1:0]    s2;
    logic signed [pbmt_pkg::LOD_W-1:0]    sq;
    logic                                 sweep_last;

    assign sweep_last = (sweep_reg == pbmt_pkg::PAIR_IDX_W'(pbmt_pkg::PAIR_COUNT - 1));

    always_comb
    begin
        state_next = state_reg;
        sweep_next = '0;
        case (state_reg)
            pbmt_pkg::ST_CLEAR:
            begin
                sweep_next = sweep_reg + pbmt_pkg::PAIR_IDX_W'(1);
                if (sweep_last)
                begin
                    state_next = pbmt_pkg::ST_IDLE;
                    sweep_next = '0;
                end
            end
            pbmt_pkg::ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = pbmt_pkg::ST_EXEC;
                end
            end
            pbmt_pkg::ST_EXEC:
            begin
                case (cmd_reg.kind)
                    pbmt_pkg::REQ_CLEAR: state_next = pbmt_pkg::ST_CLEAR;
                    pbmt_pkg::REQ_READ:
                    begin
                        if (!res_full)
                        begin
                            state_next = pbmt_pkg::ST_IDLE;
                        end
                    end
                    default:             state_next = pbmt_pkg::ST_IDLE;
                endcase
            end
            default: state_next = pbmt_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbmt_pkg::ST_CLEAR;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
        end
    end

    always_comb
    begin
        new_rec.lod_full   = cmd_reg.lod_full;
        new_rec.lod_add    = cmd_reg.lod_add;
        new_rec.pos_first  = cmd_reg.pos_a;
        new_rec.pos_second = cmd_reg.pos_b;

        stored_diff = $signed({pair_rd_reg.inter.lod_full[pbmt_pkg::LOD_W-1],
                               pair_rd_reg.inter.lod_full})
                    - $signed({pair_rd_reg.inter.lod_add[pbmt_pkg::LOD_W-1],
                               pair_rd_reg.inter.lod_add});

        upd_entry = pair_rd_reg;
        if ($signed(cmd_reg.lod_full) > $signed(pair_rd_reg.joint.lod_full))
        begin
            upd_entry.joint = new_rec;
        end
        if ($signed(cmd_reg.lod_add) > $signed(pair_rd_reg.additive.lod_add))
        begin
            upd_entry.additive = new_rec;
        end
        if ($signed(cmd_reg.lod_diff) > stored_diff)
        begin
            upd_entry.inter = new_rec;
        end

        upd_single = sgl_a_reg;
        if ($signed(cmd_reg.lod_full) > $signed(sgl_a_reg.best))
        begin
            upd_single.best = cmd_reg.lod_full;
        end
        if ($signed(cmd_reg.lod_x_single) > $signed(sgl_a_reg.best_x))
        begin
            upd_single.best_x = cmd_reg.lod_x_single;
        end
    end

    always_comb
    begin
        case (cmd_reg.criterion)
            pbmt_pkg::CRIT_JOINT: sel_rec = pair_rd_reg.joint;
            pbmt_pkg::CRIT_ADD:   sel_rec = pair_rd_reg.additive;
            pbmt_pkg::CRIT_INTER: sel_rec = pair_rd_reg.inter;
            default:              sel_rec = '0;
        endcase

        use_x = x_mask[cmd_reg.chrom_a] || x_mask[cmd_reg.chrom_b];
        s1    = use_x ? sgl_a_reg.best_x : sgl_a_reg.best;
        s2    = use_x ? sgl_b_reg.best_x : sgl_b_reg.best;
        sq    = ($signed(s1) > $signed(s2)) ? s1 : s2;
        if (sq < 0)
        begin
            sq = '0;
        end

        res_data.lod_full_at_max = sel_rec.lod_full;
        res_data.lod_add_at_max  = sel_rec.lod_add;
        res_data.pos_first       = sel_rec.pos_first;
        res_data.pos_second      = sel_rec.pos_second;
        res_data.lod_single_qtl  = sq[pbmt_pkg::SQTL_W-1:0];
    end

    always_comb
    begin
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        pair_we         = 1'b0;
        pair_waddr      = cmd_reg.pair_idx;
        pair_wdata      = upd_entry;
        sgl_we          = 1'b0;
        sgl_waddr       = cmd_reg.chrom_a;
        sgl_wdata       = upd_single;
        status.clearing = 1'b0;
        status.idle     = 1'b0;
        case (state_reg)
            pbmt_pkg::ST_CLEAR:
            begin
                status.clearing = 1'b1;
                pair_we         = 1'b1;
                pair_waddr      = sweep_reg;
                pair_wdata      = '0;
                sgl_we          = (sweep_reg < pbmt_pkg::PAIR_IDX_W'(pbmt_pkg::NUM_CHROM));
                sgl_waddr       = sweep_reg[pbmt_pkg::CHROM_W-1:0];
                sgl_wdata       = '0;
            end
            pbmt_pkg::ST_IDLE:
            begin
                status.idle = 1'b1;
                cmd_pop     = !cmd_empty;
            end
            pbmt_pkg::ST_EXEC:
            begin
                case (cmd_reg.kind)
                    pbmt_pkg::REQ_SCORE:
                    begin
                        pair_we = 1'b1;
                        sgl_we  = cmd_reg.on_diagonal;
                    end
                    pbmt_pkg::REQ_READ: res_push = !res_full;
                    default:            res_push = 1'b0;
                endcase
            end
            default: status.idle = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_we)
        begin
            pair_mem[pair_waddr] <= pair_wdata;
        end
        if (cmd_pop)
        begin
            pair_rd_reg <= pair_mem[cmd_head.pair_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sgl_we)
        begin
            sgl_mem[sgl_waddr] <= sgl_wdata;
        end
        if (cmd_pop)
        begin
            sgl_a_reg <= sgl_mem[cmd_head.chrom_a];
            sgl_b_reg <= sgl_mem[cmd_head.chrom_b];
        end
    end

endmodule

>>> sv/pbmt_result_queue.sv
// Result queue that parts the back end from the result consumer.
`timescale 1ns / 1ps

module pbmt_result_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  pbmt_pkg::res_t wr_data,
    input  logic           rd_en,
    output pbmt_pkg::res_t rd_data,
    output logic           q_full,
    output logic           q_empty
);

    pbmt_pkg::res_t slot_reg [pbmt_pkg::RES_DEPTH];

    logic [pbmt_pkg::RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pbmt_pkg::RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pbmt_pkg::RES_PTR_W:0]   count_reg, count_next;
    logic                           do_wr;
    logic                           do_rd;

    assign q_full  = (count_reg == (pbmt_pkg::RES_PTR_W+1)'(pbmt_pkg::RES_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == pbmt_pkg::RES_PTR_W'(pbmt_pkg::RES_DEPTH - 1))
                        ? '0 : wr_ptr_reg + pbmt_pkg::RES_PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == pbmt_pkg::RES_PTR_W'(pbmt_pkg::RES_DEPTH - 1))
                        ? '0 : rd_ptr_reg + pbmt_pkg::RES_PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (pbmt_pkg::RES_PTR_W+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (pbmt_pkg::RES_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/pairwise_bucket_max_tracker.sv
// Top level of the pair bucket maximum tracker: queues, front end, back end, mask register.
// A read request passes the command queue, the back end command register and the result queue, queues permitting.
// The back end handles each score or read request in two steps (store read, then update or result),
// takes no new command until it is through with the last, and holds a read while the result queue is full.
// A clear request occupies the back end for a whole sweep of the stores; full stays high while it sweeps.
// Reset: asynchronous, active low; clears the mask, then sweeps every entry of both stores.
`timescale 1ns / 1ps

module pairwise_bucket_max_tracker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [1:0]                           req_type,
    input  logic [pbmt_pkg::CHROM_W-1:0]         chrom_a,
    input  logic [pbmt_pkg::CHROM_W-1:0]         chrom_b,
    input  logic [pbmt_pkg::POS_W-1:0]           pos_a,
    input  logic [pbmt_pkg::POS_W-1:0]           pos_b,
    input  logic signed [pbmt_pkg::LOD_W-1:0]    lod_full,
    input  logic signed [pbmt_pkg::LOD_W-1:0]    lod_add,
    input  logic signed [pbmt_pkg::LOD_W-1:0]    lod_x_single,
    input  logic                                 on_diagonal,
    input  logic [1:0]                           criterion,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [pbmt_pkg::LOD_W-1:0]    lod_full_at_max,
    output logic signed [pbmt_pkg::LOD_W-1:0]    lod_add_at_max,
    output logic [pbmt_pkg::POS_W-1:0]           pos_first,
    output logic [pbmt_pkg::POS_W-1:0]           pos_second,
    output logic [pbmt_pkg::SQTL_W-1:0]          lod_single_qtl,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pbmt_pkg::MASK_W-1:0]          cfg_data
);

    logic [pbmt_pkg::MASK_W-1:0] x_mask_reg, x_mask_next;

    logic                   cmd_push;
    pbmt_pkg::cmd_t         cmd_in;
    pbmt_pkg::cmd_t         cmd_head;
    logic                   cmd_pop;
    logic                   cmd_full;
    logic                   cmd_empty;
    pbmt_pkg::res_t         res_in;
    pbmt_pkg::res_t         res_head;
    logic                   res_push;
    logic                   res_full;
    pbmt_pkg::back_status_t back_status;

    assign cfg_ready   = 1'b1;
    assign x_mask_next = (cfg_valid && cfg_ready) ? cfg_data : x_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_mask_reg <= '0;
        end
        else
        begin
            x_mask_reg <= x_mask_next;
        end
    end

    assign full = cmd_full || back_status.clearing;

    pbmt_front u_front (
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .chrom_a      (chrom_a),
        .chrom_b      (chrom_b),
        .pos_a        (pos_a),
        .pos_b        (pos_b),
        .lod_full     (lod_full),
        .lod_add      (lod_add),
        .lod_x_single (lod_x_single),
        .on_diagonal  (on_diagonal),
        .criterion    (criterion),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    pbmt_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .q_full  (cmd_full),
        .q_empty (cmd_empty)
    );

    pbmt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_head  (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .x_mask    (x_mask_reg),
        .res_data  (res_in),
        .res_push  (res_push),
        .res_full  (res_full),
        .status    (back_status)
    );

    pbmt_result_queue u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_head),
        .q_full  (res_full),
        .q_empty (empty)
    );

    assign lod_full_at_max = res_head.lod_full_at_max;
    assign lod_add_at_max  = res_head.lod_add_at_max;
    assign pos_first       = res_head.pos_first;
    assign pos_second      = res_head.pos_second;
    assign lod_single_qtl  = res_head.lod_single_qtl;

    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result transfer into a full result queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.clearing |-> (!res_push && !cmd_pop))
        else $error("back end active during clearing sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (back_status.idle && !cmd_empty))
        else $error("command taken while back end busy or queue empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> !back_status.idle)
        else $error("back end did not start executing a taken command");

endmodule
